### src/piet_stack_machine_execute_macros.svh
// Assertion macros shared by the stack machine RTL
`ifndef PIET_STACK_MACHINE_EXECUTE_MACROS_SVH
`define PIET_STACK_MACHINE_EXECUTE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PSM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("stack machine check failed");

// next-cycle implication, checked out of reset
`define PSM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("stack machine check failed");

`endif

### src/piet_sm_pkg.sv
// Package: constants, codes and types of the stack machine
`default_nettype none
package piet_sm_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;

    localparam logic [4:0] CMD_ADD      = 5'd1;
    localparam logic [4:0] CMD_DIV      = 5'd2;
    localparam logic [4:0] CMD_GREATER  = 5'd3;
    localparam logic [4:0] CMD_DUP      = 5'd4;
    localparam logic [4:0] CMD_IN_CHAR  = 5'd5;
    localparam logic [4:0] CMD_PUSH     = 5'd6;
    localparam logic [4:0] CMD_SUB      = 5'd7;
    localparam logic [4:0] CMD_MOD      = 5'd8;
    localparam logic [4:0] CMD_POINTER  = 5'd9;
    localparam logic [4:0] CMD_ROLL     = 5'd10;
    localparam logic [4:0] CMD_OUT_NUM  = 5'd11;
    localparam logic [4:0] CMD_POP      = 5'd12;
    localparam logic [4:0] CMD_MUL      = 5'd13;
    localparam logic [4:0] CMD_NOT      = 5'd14;
    localparam logic [4:0] CMD_SWITCH   = 5'd15;
    localparam logic [4:0] CMD_IN_NUM   = 5'd16;
    localparam logic [4:0] CMD_OUT_CHAR = 5'd17;

    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_UNDER = 3'd1;
    localparam logic [2:0] STAT_OVER  = 3'd2;
    localparam logic [2:0] STAT_DIV0  = 3'd3;
    localparam logic [2:0] STAT_ROLL  = 3'd4;

    typedef enum logic [4:0] {
        OP_NOP, OP_DUP, OP_PUSHV, OP_POP, OP_POINTER, OP_SWITCH, OP_OUT_NUM,
        OP_OUT_CHAR, OP_NOT, OP_ADD, OP_SUB, OP_MUL, OP_GREATER, OP_DIV,
        OP_MOD, OP_ROLL
    } op_t;

    // decoded instruction passed from front to back
    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] val;
    } instr_t;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_OPND, S_DIV, S_WBACK, S_R1RD, S_R1WR, S_R2RD,
        S_R2WR, S_RELOAD, S_DONE
    } state_t;

endpackage
`default_nettype wire

### src/piet_sm_ram.sv
// Generic single-write, single-read RAM with registered read
`default_nettype none
module piet_sm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### src/piet_sm_div.sv
// Radix-2 signed divider, truncating quotient and remainder
`default_nettype none
module piet_sm_div
    import piet_sm_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic      [DATA_W-1:0] quot,
    output logic      [DATA_W-1:0] rem
);

    localparam int STEP_W = $clog2(DATA_W + 1);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic              qneg_reg, qneg_next;
    logic              rneg_reg, rneg_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        done      = busy_reg && (step_reg == '0);
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(DATA_W);
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            dvs_next  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            qneg_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            rneg_next = dividend[DATA_W-1];
        end else if (busy_reg) begin
            if (step_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                step_next = step_reg - 1'b1;
                if (!diff[DATA_W]) begin
                    rem_next = diff[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end else begin
                    rem_next = shifted[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
            end
        end
        quot = qneg_reg ? (~quo_reg + 1'b1) : quo_reg;
        rem  = rneg_reg ? (~rem_reg + 1'b1) : rem_reg;
    end

endmodule
`default_nettype wire

### src/piet_sm_front.sv
// Front end: accepts commands, decodes them and queues them for the back end
`default_nettype none
module piet_sm_front
    import piet_sm_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [4:0]               s_command,
    input  wire logic [23:0]              s_codel_value,
    input  wire logic signed [DATA_W-1:0] s_input_value,
    output logic                          q_valid,
    output instr_t                        q_item,
    input  wire logic                     q_pop
);

    instr_t     fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    instr_t     dec;

    always_comb begin
        dec.val = DATA_W'(s_codel_value);
        case (s_command)
            CMD_ADD:      dec.op = OP_ADD;
            CMD_DIV:      dec.op = OP_DIV;
            CMD_GREATER:  dec.op = OP_GREATER;
            CMD_DUP:      dec.op = OP_DUP;
            CMD_IN_CHAR:  dec.op = OP_PUSHV;
            CMD_PUSH:     dec.op = OP_PUSHV;
            CMD_SUB:      dec.op = OP_SUB;
            CMD_MOD:      dec.op = OP_MOD;
            CMD_POINTER:  dec.op = OP_POINTER;
            CMD_ROLL:     dec.op = OP_ROLL;
            CMD_OUT_NUM:  dec.op = OP_OUT_NUM;
            CMD_POP:      dec.op = OP_POP;
            CMD_MUL:      dec.op = OP_MUL;
            CMD_NOT:      dec.op = OP_NOT;
            CMD_SWITCH:   dec.op = OP_SWITCH;
            CMD_IN_NUM:   dec.op = OP_PUSHV;
            CMD_OUT_CHAR: dec.op = OP_OUT_CHAR;
            default:      dec.op = OP_NOP;
        endcase
        if (s_command == CMD_IN_CHAR || s_command == CMD_IN_NUM) begin
            dec.val = s_input_value;
        end
    end

    assign s_ready = (fill_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (push) begin
            fifo_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule
`default_nettype wire

### src/piet_sm_back.sv
// Back end: sequencer that runs queued instructions against the stack
`default_nettype none
module piet_sm_back
    import piet_sm_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     q_valid,
    input  wire instr_t                   q_item,
    output logic                          q_pop,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic      [2:0]               m_status,
    output logic                          m_out_valid,
    output logic                          m_out_is_char,
    output logic signed [DATA_W-1:0]      m_out_value,
    output logic      [1:0]               m_dir_now,
    output logic                          m_chooser_now,
    output logic      [8:0]               m_depth_now,
    output logic signed [DATA_W-1:0]      m_top_now
);

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [1:0]        dir_reg, dir_next;
    logic              ch_reg, ch_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [2:0]        stat_reg, stat_next;
    logic              ov_reg, ov_next;
    logic              oc_reg, oc_next;
    logic [DATA_W-1:0] oval_reg, oval_next;
    logic [ADDR_W-1:0] d_reg, d_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic              mv_reg, mv_next;

    logic              st_we, bf_we;
    logic [ADDR_W-1:0] st_waddr, st_raddr, bf_waddr, bf_raddr;
    logic [DATA_W-1:0] st_wdata, st_rdata, bf_wdata, bf_rdata;

    logic              div_start, div_done;
    logic [DATA_W-1:0] div_a, div_b, div_q, div_r, rmod;
    logic [CNT_W-1:0]  cnt_m1, cnt_m2, cnt_m3;
    logic [DATA_W-1:0] push_val;

    piet_sm_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    piet_sm_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_rollbuf (
        .aclk(aclk), .we(bf_we), .waddr(bf_waddr), .wdata(bf_wdata),
        .raddr(bf_raddr), .rdata(bf_rdata)
    );

    piet_sm_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quot(div_q), .rem(div_r)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            top_reg   <= '0;
            dir_reg   <= 2'd0;
            ch_reg    <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            top_reg   <= top_next;
            dir_reg   <= dir_next;
            ch_reg    <= ch_next;
            mv_reg    <= mv_next;
        end
        op_reg   <= op_next;
        val_reg  <= val_next;
        res_reg  <= res_next;
        stat_reg <= stat_next;
        ov_reg   <= ov_next;
        oc_reg   <= oc_next;
        oval_reg <= oval_next;
        d_reg    <= d_next;
        base_reg <= base_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        if (state_reg == S_DONE && (!mv_reg || m_ready)) begin
            m_status      <= stat_reg;
            m_out_valid   <= ov_reg;
            m_out_is_char <= oc_reg;
            m_out_value   <= oval_reg;
            m_dir_now     <= dir_reg;
            m_chooser_now <= ch_reg;
            m_depth_now   <= 9'(cnt_reg);
            m_top_now     <= top_reg;
        end
    end

    assign m_valid = mv_reg;
    assign cnt_m1  = cnt_reg - CNT_W'(1);
    assign cnt_m2  = cnt_reg - CNT_W'(2);
    assign cnt_m3  = cnt_reg - CNT_W'(3);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        cnt_next   = cnt_reg;
        top_next   = top_reg;
        dir_next   = dir_reg;
        ch_next    = ch_reg;
        res_next   = res_reg;
        stat_next  = stat_reg;
        ov_next    = ov_reg;
        oc_next    = oc_reg;
        oval_next  = oval_reg;
        d_next     = d_reg;
        base_next  = base_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        mv_next    = mv_reg && !m_ready;
        q_pop      = 1'b0;
        st_we      = 1'b0;
        st_waddr   = cnt_reg[ADDR_W-1:0];
        st_wdata   = top_reg;
        st_raddr   = cnt_m2[ADDR_W-1:0];
        bf_we      = 1'b0;
        bf_waddr   = j_reg;
        bf_wdata   = st_rdata;
        bf_raddr   = i_reg;
        div_start  = 1'b0;
        div_a      = st_rdata;
        div_b      = top_reg;
        push_val   = (op_reg == OP_DUP) ? top_reg : val_reg;
        rmod       = div_r[DATA_W-1] ? (div_r + DATA_W'(d_reg)) : div_r;

        case (state_reg)
            S_IDLE: begin
                stat_next = STAT_OK;
                ov_next   = 1'b0;
                oc_next   = 1'b0;
                oval_next = '0;
                if (q_valid) begin
                    q_pop      = 1'b1;
                    op_next    = q_item.op;
                    val_next   = q_item.val;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                case (op_reg)
                    OP_DUP, OP_PUSHV: begin
                        if (op_reg == OP_DUP && cnt_reg == '0) begin
                            stat_next = STAT_UNDER;
                        end else if (cnt_reg >= CNT_W'(STACK_DEPTH)) begin
                            stat_next = STAT_OVER;
                        end else begin
                            st_we    = 1'b1;
                            st_wdata = push_val;
                            top_next = push_val;
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    OP_POP, OP_POINTER, OP_SWITCH, OP_OUT_NUM, OP_OUT_CHAR: begin
                        if (cnt_reg == '0) begin
                            stat_next = STAT_UNDER;
                        end else begin
                            cnt_next   = cnt_m1;
                            state_next = S_RELOAD;
                            if (op_reg == OP_POINTER) begin
                                dir_next = dir_reg + top_reg[1:0];
                            end
                            if (op_reg == OP_SWITCH) begin
                                ch_next = ch_reg ^ top_reg[0];
                            end
                            if (op_reg == OP_OUT_NUM || op_reg == OP_OUT_CHAR) begin
                                ov_next   = 1'b1;
                                oc_next   = (op_reg == OP_OUT_CHAR);
                                oval_next = top_reg;
                            end
                        end
                    end
                    OP_NOT: begin
                        if (cnt_reg == '0) begin
                            stat_next = STAT_UNDER;
                        end else begin
                            st_we    = 1'b1;
                            st_waddr = cnt_m1[ADDR_W-1:0];
                            st_wdata = DATA_W'(top_reg == '0);
                            top_next = DATA_W'(top_reg == '0);
                        end
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_GREATER, OP_DIV, OP_MOD, OP_ROLL: begin
                        if (cnt_reg < CNT_W'(2)) begin
                            stat_next = STAT_UNDER;
                        end else begin
                            state_next = S_OPND;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_OPND: begin
                // st_rdata holds the second element, top_reg the first
                state_next = S_WBACK;
                case (op_reg)
                    OP_ADD:     res_next = st_rdata + top_reg;
                    OP_SUB:     res_next = st_rdata - top_reg;
                    OP_MUL:     res_next = st_rdata * top_reg;
                    OP_GREATER: res_next = DATA_W'($signed(st_rdata) > $signed(top_reg));
                    OP_DIV, OP_MOD: begin
                        if (top_reg == '0) begin
                            stat_next  = STAT_DIV0;
                            state_next = S_DONE;
                        end else begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    OP_ROLL: begin
                        if (st_rdata[DATA_W-1] || st_rdata > DATA_W'(cnt_m2)) begin
                            stat_next  = STAT_ROLL;
                            state_next = S_DONE;
                        end else begin
                            cnt_next  = cnt_m2;
                            d_next    = st_rdata[ADDR_W-1:0];
                            base_next = cnt_m2[ADDR_W-1:0] - st_rdata[ADDR_W-1:0];
                            if (st_rdata == '0) begin
                                st_raddr   = cnt_m3[ADDR_W-1:0];
                                state_next = S_RELOAD;
                            end else begin
                                // rolls modulo depth
                                div_a      = top_reg;
                                div_b      = st_rdata;
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    if (op_reg == OP_ROLL) begin
                        j_next     = rmod[ADDR_W-1:0];
                        i_next     = '0;
                        state_next = S_R1RD;
                    end else begin
                        res_next   = (op_reg == OP_DIV) ? div_q : div_r;
                        state_next = S_WBACK;
                    end
                end
            end
            S_WBACK: begin
                st_we      = 1'b1;
                st_waddr   = cnt_m2[ADDR_W-1:0];
                st_wdata   = res_reg;
                top_next   = res_reg;
                cnt_next   = cnt_m1;
                state_next = S_DONE;
            end
            S_R1RD: begin
                st_raddr   = base_reg + i_reg;
                state_next = S_R1WR;
            end
            S_R1WR: begin
                bf_we  = 1'b1;
                j_next = (j_reg == d_reg - 1'b1) ? '0 : j_reg + 1'b1;
                if (i_reg == d_reg - 1'b1) begin
                    i_next     = '0;
                    state_next = S_R2RD;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_R1RD;
                end
            end
            S_R2RD: begin
                state_next = S_R2WR;
            end
            S_R2WR: begin
                st_we    = 1'b1;
                st_waddr = base_reg + i_reg;
                st_wdata = bf_rdata;
                if (i_reg == d_reg - 1'b1) begin
                    // last entry written is the new top
                    top_next   = bf_rdata;
                    state_next = S_DONE;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_R2RD;
                end
            end
            S_RELOAD: begin
                top_next   = (cnt_reg == '0) ? '0 : st_rdata;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### src/piet_stack_machine_execute.sv
// Top level of the Piet stack-machine executor
//
//  channel  ports  direction  transaction
//  command  s_*    in         one command with codel and input values
//  result   m_*    out        status, output value and machine state
//
// Divide and modulo run through the radix-2 divider. Roll of depth d uses the
// divider for rolls mod d, then copies the top d entries into the roll buffer
// and back onto the stack.
// A two-entry queue keeps accepting commands while the back end is busy, until it is full.
// Reset is synchronous: empty stack, pointer right, chooser left.
`default_nettype none
`include "piet_stack_machine_execute_macros.svh"
module piet_stack_machine_execute
    import piet_sm_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [4:0]               s_command,
    input  wire logic [23:0]              s_codel_value,
    input  wire logic signed [DATA_W-1:0] s_input_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic      [2:0]               m_status,
    output logic                          m_out_valid,
    output logic                          m_out_is_char,
    output logic signed [DATA_W-1:0]      m_out_value,
    output logic      [1:0]               m_dir_now,
    output logic                          m_chooser_now,
    output logic      [8:0]               m_depth_now,
    output logic signed [DATA_W-1:0]      m_top_now
);

    logic   q_valid;
    logic   q_pop;
    instr_t q_item;

    piet_sm_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_codel_value(s_codel_value),
        .s_input_value(s_input_value), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop)
    );

    piet_sm_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop), .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_out_valid(m_out_valid), .m_out_is_char(m_out_is_char),
        .m_out_value(m_out_value), .m_dir_now(m_dir_now),
        .m_chooser_now(m_chooser_now), .m_depth_now(m_depth_now),
        .m_top_now(m_top_now)
    );

    `PSM_ASSERT_NOW(a_pop_needs_item, aclk, aresetn, q_pop, q_valid)
    `PSM_ASSERT_NOW(a_empty_top_zero, aclk, aresetn, m_valid && m_depth_now == 9'd0, m_top_now == '0)
    `PSM_ASSERT_NOW(a_err_no_output, aclk, aresetn, m_valid && m_status != STAT_OK, !m_out_valid)
    `PSM_ASSERT_NOW(a_no_output_clear, aclk, aresetn, m_valid && !m_out_valid, m_out_value == '0 && !m_out_is_char)

endmodule
`default_nettype wire
